// ----- sv/levi_civita_rk4_step_unit_assert.svh -----
// Assertion macros for the Levi-Civita RK4 step unit.
// No dependencies; included by the files that check their own logic.
`ifndef LEVI_CIVITA_RK4_STEP_UNIT_ASSERT_SVH
`define LEVI_CIVITA_RK4_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define LCRK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCRK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lcrk_pkg.sv -----
// Types, constants and saturating fixed-point helpers for the RK4 step unit.
// No dependencies.
package lcrk_pkg;

    typedef logic signed [31:0] sword_t;
    typedef logic [31:0]        uword_t;

    localparam sword_t SWORD_MAX = 32'sh7FFF_FFFF;
    localparam sword_t SWORD_MIN = 32'sh8000_0000;
    localparam uword_t UWORD_MAX = 32'hFFFF_FFFF;
    // ceil(2^33 / 3): floor(m/3) = (m * RECIP3) >> 33 for any 32-bit m
    localparam uword_t RECIP3    = 32'hAAAA_AAAB;

    localparam logic [1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [1:0] REG_MASS_TERM = 2'd1;

    typedef struct packed {
        logic   mode;
        sword_t load_u1;
        sword_t load_u2;
        sword_t load_v1;
        sword_t load_v2;
    } lcrk_in_t;

    typedef struct packed {
        sword_t pos_1;
        sword_t pos_2;
        sword_t vel_1;
        sword_t vel_2;
        uword_t pos_norm_sq;
        logic   fault;
    } lcrk_out_t;

    typedef struct packed {
        sword_t val;
        logic   ovf;
    } sres_t;

    typedef struct packed {
        uword_t val;
        logic   ovf;
    } ures_t;

    typedef struct packed {
        logic   start;
        uword_t rem0;
        uword_t low;
        uword_t den;
    } lcrk_div_req_t;

    typedef struct packed {
        logic   done;
        uword_t quo;
    } lcrk_div_resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_NUM,
        ST_DIV,
        ST_EU,
        ST_KH,
        ST_KDIV,
        ST_NSQ,
        ST_OUT
    } lcrk_state_t;

    function automatic uword_t mag(input sword_t x);
        return x[31] ? (~uword_t'(x) + 32'd1) : uword_t'(x);
    endfunction

    function automatic sword_t apply_sign(input uword_t m, input logic neg);
        return neg ? sword_t'(~m + 32'd1) : sword_t'(m);
    endfunction

    function automatic sres_t from_mag(input logic [47:0] m, input logic neg);
        sres_t r;
        r.ovf = 1'b0;
        r.val = sword_t'(m[31:0]);
        if (neg) begin
            if (m > 48'h0000_8000_0000) begin
                r.val = SWORD_MIN;
                r.ovf = 1'b1;
            end else begin
                r.val = sword_t'(~m[31:0] + 32'd1);
            end
        end else if (m > 48'h0000_7FFF_FFFF) begin
            r.val = SWORD_MAX;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    function automatic sres_t sadd(input sword_t a, input sword_t b);
        logic signed [32:0] s;
        sres_t r;
        s = {a[31], a} + {b[31], b};
        r.ovf = (s[32] != s[31]);
        r.val = r.ovf ? (s[32] ? SWORD_MIN : SWORD_MAX) : sword_t'(s[31:0]);
        return r;
    endfunction

    // square magnitude product, shifted by the fraction width
    function automatic ures_t usq(input logic [63:0] p);
        ures_t r;
        r.ovf = (p[63:48] != 16'd0);
        r.val = r.ovf ? UWORD_MAX : p[47:16];
        return r;
    endfunction

    function automatic ures_t uadd(input uword_t a, input uword_t b);
        logic [32:0] s;
        ures_t r;
        s = {1'b0, a} + {1'b0, b};
        r.ovf = s[32];
        r.val = s[32] ? UWORD_MAX : s[31:0];
        return r;
    endfunction

endpackage

// ----- sv/lcrk_mul.sv -----
// Shared 32x32 unsigned multiplier with registered product.
// Depends on lcrk_pkg.
module lcrk_mul
    import lcrk_pkg::*;
(
    input  logic        aclk,
    input  uword_t      op_a,
    input  uword_t      op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- sv/lcrk_div.sv -----
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// Depends on lcrk_pkg. Caller guarantees rem0 < den.
module lcrk_div
    import lcrk_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  lcrk_div_req_t  req,
    output lcrk_div_resp_t resp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    uword_t      rem_reg, rem_next;
    uword_t      low_reg, low_next;
    uword_t      quo_reg, quo_next;
    uword_t      den_reg, den_next;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, low_reg[31]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = req.rem0;
            low_next  = req.low;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            low_next = {low_reg[30:0], 1'b0};
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign resp.done = done_reg;
    assign resp.quo  = quo_reg;

endmodule

// ----- sv/levi_civita_rk4_step_unit.sv -----
// Top level of the Levi-Civita RK4 step unit: sequencer, state and config.
// Depends on lcrk_pkg, lcrk_mul, lcrk_div and the assertion macro header.
`include "levi_civita_rk4_step_unit_assert.svh"

// Keeps a 2D regularized two-body state (u1, u2, v1, v2) in signed Q16.16 and
// handles one item at a time. mode 0 loads the state, mode 1 takes one RK4
// step of size step_size on u' = v, v' = 0.5*E*u, E = (2|v|^2 - mu)/|u|^2.
// Every item returns the new state, |u|^2 and a fault flag (any saturation
// or division by zero). s_ready is high only while idle. A load goes from
// acceptance through the |u|^2 pass to the result. A step goes from
// acceptance through four derivative evaluations (each fourteen passes
// through the one shared 32x32 multiplier, a numerator step and a wait on
// the bit-serial divider for E), the |u|^2 pass and the result. An
// evaluation with zero |u|^2 or an overflowing E skips the divider. The
// result is held on m_data until its transfer.
// Configuration (step_size at index 0, mass_term at index 1) is to be
// written through cfg_wr_en/cfg_index/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
module levi_civita_rk4_step_unit
    import lcrk_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lcrk_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lcrk_out_t m_data,
    input  logic      cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_wdata
);

    // sequencer
    lcrk_state_t state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;   // component within a pass
    logic        ph_reg, ph_next;     // 0: operands to multiplier, 1: take product
    logic [1:0]  stg_reg, stg_next;   // which k (k1..k4)
    logic [1:0]  idx_last;

    // config
    sword_t      step_reg;
    logic [30:0] mass_reg;

    // state and working values
    sword_t y_reg   [4];
    sword_t y_next  [4];
    sword_t acc_reg [4];              // running y + k1/6 + k2/3 + ...
    sword_t acc_next[4];
    sword_t t_reg   [4];              // point for the current derivative
    sword_t t_next  [4];
    sword_t k_reg   [4];
    sword_t k_next  [4];
    sword_t d_reg   [2];              // 0.5*E*u1, 0.5*E*u2
    sword_t d_next  [2];
    sword_t e_reg, e_next;
    uword_t vsq_reg, vsq_next;
    uword_t den_reg, den_next;
    uword_t nsq_reg, nsq_next;
    logic   num_neg_reg, num_neg_next;
    logic   flt_reg, flt_next;

    // shared units
    uword_t         mul_a, mul_b;
    logic [63:0]    prod;
    lcrk_div_req_t  div_req;
    lcrk_div_resp_t div_resp;

    // scratch
    logic        s_xfer, m_xfer;
    logic [32:0] twov, mu33, diff;
    uword_t      nmag;
    sword_t      dsel, qs, half;
    sres_t       sr, sr2;
    ures_t       ur, ur2;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;

    lcrk_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    lcrk_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    assign idx_last = (state_reg == ST_EU || state_reg == ST_NSQ) ? 2'd1 : 2'd3;

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        stg_next   = stg_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    idx_next   = 2'd0;
                    ph_next    = 1'b0;
                    stg_next   = 2'd0;
                    state_next = s_data.mode ? ST_SQ : ST_NSQ;
                end
            end
            ST_SQ, ST_EU, ST_KH, ST_KDIV, ST_NSQ: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else begin
                    ph_next = 1'b0;
                    if (idx_reg != idx_last) begin
                        idx_next = idx_reg + 2'd1;
                    end else begin
                        idx_next = 2'd0;
                        case (state_reg)
                            ST_SQ:   state_next = ST_NUM;
                            ST_EU:   state_next = ST_KH;
                            ST_KH:   state_next = ST_KDIV;
                            ST_NSQ:  state_next = ST_OUT;
                            default: begin
                                if (stg_reg == 2'd3) begin
                                    state_next = ST_NSQ;
                                end else begin
                                    stg_next   = stg_reg + 2'd1;
                                    state_next = ST_SQ;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_NUM:  state_next = div_req.start ? ST_DIV : ST_EU;
            ST_DIV:  if (div_resp.done) state_next = ST_EU;
            ST_OUT:  if (m_xfer) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            y_next[j]   = y_reg[j];
            acc_next[j] = acc_reg[j];
            t_next[j]   = t_reg[j];
            k_next[j]   = k_reg[j];
        end
        d_next[0]    = d_reg[0];
        d_next[1]    = d_reg[1];
        e_next       = e_reg;
        vsq_next     = vsq_reg;
        den_next     = den_reg;
        nsq_next     = nsq_reg;
        num_neg_next = num_neg_reg;
        flt_next     = flt_reg;
        mul_a        = 32'd0;
        mul_b        = 32'd0;
        div_req      = '0;
        twov         = {vsq_reg, 1'b0};
        mu33         = {2'b00, mass_reg};
        diff         = 33'd0;
        nmag         = 32'd0;
        dsel         = 32'sd0;
        qs           = 32'sd0;
        half         = 32'sd0;
        sr           = '0;
        sr2          = '0;
        ur           = usq(prod);
        ur2          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    flt_next = 1'b0;
                    if (!s_data.mode) begin
                        y_next[0] = s_data.load_u1;
                        y_next[1] = s_data.load_u2;
                        y_next[2] = s_data.load_v1;
                        y_next[3] = s_data.load_v2;
                        acc_next[0] = s_data.load_u1;
                        acc_next[1] = s_data.load_u2;
                        acc_next[2] = s_data.load_v1;
                        acc_next[3] = s_data.load_v2;
                    end else begin
                        for (int j = 0; j < 4; j++) begin
                            t_next[j]   = y_reg[j];
                            acc_next[j] = y_reg[j];
                        end
                    end
                end
            end
            ST_SQ: begin
                mul_a = mag(t_reg[idx_reg]);
                mul_b = mag(t_reg[idx_reg]);
                if (ph_reg) begin
                    case (idx_reg)
                        2'd0: begin
                            den_next = ur.val;
                            flt_next = flt_reg | ur.ovf;
                        end
                        2'd1: begin
                            ur2      = uadd(den_reg, ur.val);
                            den_next = ur2.val;
                            flt_next = flt_reg | ur.ovf | ur2.ovf;
                        end
                        2'd2: begin
                            vsq_next = ur.val;
                            flt_next = flt_reg | ur.ovf;
                        end
                        default: begin
                            ur2      = uadd(vsq_reg, ur.val);
                            vsq_next = ur2.val;
                            flt_next = flt_reg | ur.ovf | ur2.ovf;
                        end
                    endcase
                end
            end
            ST_NUM: begin
                // numerator 2|v|^2 - mu, kept as sign and magnitude
                if (twov >= mu33) begin
                    diff         = twov - mu33;
                    num_neg_next = 1'b0;
                    if (diff > 33'h0_7FFF_FFFF) begin
                        nmag     = 32'h7FFF_FFFF;
                        flt_next = 1'b1;
                    end else begin
                        nmag = diff[31:0];
                    end
                end else begin
                    diff         = mu33 - twov;
                    num_neg_next = 1'b1;
                    nmag         = diff[31:0];
                end
                if (den_reg == 32'd0) begin
                    flt_next = 1'b1;
                    e_next   = (nmag == 32'd0) ? 32'sd0 :
                               (num_neg_next ? SWORD_MIN : SWORD_MAX);
                end else if ({16'd0, nmag[31:16]} >= den_reg) begin
                    // quotient would need more than 32 bits
                    flt_next = 1'b1;
                    e_next   = num_neg_next ? SWORD_MIN : SWORD_MAX;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem0  = {16'd0, nmag[31:16]};
                    div_req.low   = {nmag[15:0], 16'd0};
                    div_req.den   = den_reg;
                end
            end
            ST_DIV: begin
                if (div_resp.done) begin
                    sr       = from_mag({16'd0, div_resp.quo}, num_neg_reg);
                    e_next   = sr.val;
                    flt_next = flt_reg | sr.ovf;
                end
            end
            ST_EU: begin
                mul_a = mag(e_reg);
                mul_b = mag(t_reg[idx_reg]);
                if (ph_reg) begin
                    sr = from_mag({1'b0, prod[63:17]}, e_reg[31] ^ t_reg[idx_reg][31]);
                    d_next[idx_reg[0]] = sr.val;
                    flt_next = flt_reg | sr.ovf;
                end
            end
            ST_KH: begin
                case (idx_reg)
                    2'd0:    dsel = t_reg[2];
                    2'd1:    dsel = t_reg[3];
                    2'd2:    dsel = d_reg[0];
                    default: dsel = d_reg[1];
                endcase
                mul_a = mag(dsel);
                mul_b = mag(step_reg);
                if (ph_reg) begin
                    sr = from_mag(prod[63:16], dsel[31] ^ step_reg[31]);
                    k_next[idx_reg] = sr.val;
                    flt_next = flt_reg | sr.ovf;
                end
            end
            ST_KDIV: begin
                mul_a = mag(k_reg[idx_reg]);
                mul_b = RECIP3;
                if (ph_reg) begin
                    // k/3 for k2 and k3, k/6 for k1 and k4, toward zero
                    if (stg_reg == 2'd1 || stg_reg == 2'd2) begin
                        qs = apply_sign({1'b0, prod[63:33]}, k_reg[idx_reg][31]);
                    end else begin
                        qs = apply_sign({2'b00, prod[63:34]}, k_reg[idx_reg][31]);
                    end
                    sr = sadd(acc_reg[idx_reg], qs);
                    acc_next[idx_reg] = sr.val;
                    half = apply_sign(mag(k_reg[idx_reg]) >> 1, k_reg[idx_reg][31]);
                    case (stg_reg)
                        2'd0, 2'd1: begin
                            sr2 = sadd(y_reg[idx_reg], half);
                            t_next[idx_reg] = sr2.val;
                        end
                        2'd2: begin
                            sr2 = sadd(y_reg[idx_reg], k_reg[idx_reg]);
                            t_next[idx_reg] = sr2.val;
                        end
                        default: sr2 = '0;
                    endcase
                    flt_next = flt_reg | sr.ovf | sr2.ovf;
                end
            end
            ST_NSQ: begin
                for (int j = 0; j < 4; j++) begin
                    y_next[j] = acc_reg[j];
                end
                mul_a = mag(acc_reg[idx_reg]);
                mul_b = mag(acc_reg[idx_reg]);
                if (ph_reg) begin
                    if (idx_reg == 2'd0) begin
                        nsq_next = ur.val;
                        flt_next = flt_reg | ur.ovf;
                    end else begin
                        ur2      = uadd(nsq_reg, ur.val);
                        nsq_next = ur2.val;
                        flt_next = flt_reg | ur.ovf | ur2.ovf;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
            ph_reg    <= 1'b0;
            stg_reg   <= 2'd0;
            flt_reg   <= 1'b0;
            for (int j = 0; j < 4; j++) begin
                y_reg[j]   <= 32'sd0;
                acc_reg[j] <= 32'sd0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
            stg_reg   <= stg_next;
            flt_reg   <= flt_next;
            for (int j = 0; j < 4; j++) begin
                y_reg[j]   <= y_next[j];
                acc_reg[j] <= acc_next[j];
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        for (int j = 0; j < 4; j++) begin
            t_reg[j] <= t_next[j];
            k_reg[j] <= k_next[j];
        end
        d_reg[0]    <= d_next[0];
        d_reg[1]    <= d_next[1];
        e_reg       <= e_next;
        vsq_reg     <= vsq_next;
        den_reg     <= den_next;
        nsq_reg     <= nsq_next;
        num_neg_reg <= num_neg_next;
    end

    // config writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 32'sd0;
            mass_reg <= 31'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_SIZE: step_reg <= sword_t'(cfg_wdata);
                REG_MASS_TERM: mass_reg <= cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    assign m_data.pos_1       = acc_reg[0];
    assign m_data.pos_2       = acc_reg[1];
    assign m_data.vel_1       = acc_reg[2];
    assign m_data.vel_2       = acc_reg[3];
    assign m_data.pos_norm_sq = nsq_reg;
    assign m_data.fault       = flt_reg;

    // one item in flight: never ready while a result is offered
    `LCRK_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "ready while result pending")
    // divider finishes only while the sequencer waits for it
    `LCRK_ASSERT_IMP(a_div_wait, aclk, aresetn, div_resp.done, state_reg == ST_DIV, "stray divider done")
    // a load goes straight to the norm pass
    `LCRK_ASSERT_NXT(a_load_path, aclk, aresetn, s_xfer && !s_data.mode, state_reg == ST_NSQ, "load path")
    // after a result transfer the block is ready again
    `LCRK_ASSERT_NXT(a_out_done, aclk, aresetn, m_xfer, s_ready, "not idle after transfer")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Levi-Civita RK4 step unit.
// Depends on lcrk_pkg and levi_civita_rk4_step_unit; drives random traffic and checks results.
module tb
    import lcrk_pkg::*;
();

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam longint UMAX = 64'sd4294967295;
    localparam int CYCLE_LIMIT = 3000000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lcrk_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lcrk_out_t m_data;
    logic      cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = REG_STEP_SIZE;
    logic [31:0] cfg_wdata = '0;

    levi_civita_rk4_step_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: mirrors the block's saturating Q16.16 arithmetic.
    // Values are kept in longint so every intermediate is exact.
    // ---------------------------------------------------------------
    longint st_pos[2];
    longint st_vel[2];
    longint h_cfg  = 0;
    longint mu_cfg = 65536;
    bit     sat_hit;

    function automatic longint clamp_word(input longint x);
        if (x > SMAX) begin sat_hit = 1'b1; return SMAX; end
        if (x < SMIN) begin sat_hit = 1'b1; return SMIN; end
        return x;
    endfunction

    function automatic longint abs_l(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint signed_mag(input longint m, input bit neg);
        if (neg) begin
            if (m > SMAX + 1) begin sat_hit = 1'b1; return SMIN; end
            return -m;
        end
        if (m > SMAX) begin sat_hit = 1'b1; return SMAX; end
        return m;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b, input int sh);
        longint m;
        m = (abs_l(a) * abs_l(b)) >>> sh;
        return signed_mag(m, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_sq(input longint a);
        longint m;
        m = (abs_l(a) * abs_l(a)) >>> 16;
        if (m > UMAX) begin sat_hit = 1'b1; return UMAX; end
        return m;
    endfunction

    function automatic longint fx_uadd(input longint a, input longint b);
        if (a + b > UMAX) begin sat_hit = 1'b1; return UMAX; end
        return a + b;
    endfunction

    function automatic longint energy_div(input longint num, input longint den);
        if (den == 0) begin
            sat_hit = 1'b1;
            return num > 0 ? SMAX : (num < 0 ? SMIN : 0);
        end
        return signed_mag((abs_l(num) << 16) / den, num < 0);
    endfunction

    // k = h * (v, 0.5*E*u)
    function automatic void slope_times_h(input longint y[4], input longint h,
                                          output longint k[4]);
        longint vsq, den, num, e, vsq2;
        longint d[4];
        vsq  = fx_uadd(fx_sq(y[2]), fx_sq(y[3]));
        den  = fx_uadd(fx_sq(y[0]), fx_sq(y[1]));
        vsq2 = vsq << 1;
        if (vsq2 >= mu_cfg) num = signed_mag(vsq2 - mu_cfg, 1'b0);
        else                num = signed_mag(mu_cfg - vsq2, 1'b1);
        e = energy_div(num, den);
        d[0] = y[2];
        d[1] = y[3];
        d[2] = fx_mul(e, y[0], 17);
        d[3] = fx_mul(e, y[1], 17);
        for (int i = 0; i < 4; i++) k[i] = fx_mul(d[i], h, 16);
    endfunction

    function automatic lcrk_out_t rk4_predict(input lcrk_in_t x);
        longint y[4], t[4], k1[4], k2[4], k3[4], k4[4];
        longint r;
        lcrk_out_t o;
        sat_hit = 1'b0;
        if (!x.mode) begin
            st_pos[0] = longint'(x.load_u1);
            st_pos[1] = longint'(x.load_u2);
            st_vel[0] = longint'(x.load_v1);
            st_vel[1] = longint'(x.load_v2);
        end else begin
            y[0] = st_pos[0]; y[1] = st_pos[1]; y[2] = st_vel[0]; y[3] = st_vel[1];
            slope_times_h(y, h_cfg, k1);
            for (int i = 0; i < 4; i++) t[i] = clamp_word(y[i] + k1[i] / 2);
            slope_times_h(t, h_cfg, k2);
            for (int i = 0; i < 4; i++) t[i] = clamp_word(y[i] + k2[i] / 2);
            slope_times_h(t, h_cfg, k3);
            for (int i = 0; i < 4; i++) t[i] = clamp_word(y[i] + k3[i]);
            slope_times_h(t, h_cfg, k4);
            for (int i = 0; i < 4; i++) begin
                r = clamp_word(y[i] + k1[i] / 6);
                r = clamp_word(r + k2[i] / 3);
                r = clamp_word(r + k3[i] / 3);
                y[i] = clamp_word(r + k4[i] / 6);
            end
            st_pos[0] = y[0]; st_pos[1] = y[1]; st_vel[0] = y[2]; st_vel[1] = y[3];
        end
        o.pos_norm_sq = uword_t'(fx_uadd(fx_sq(st_pos[0]), fx_sq(st_pos[1])));
        o.pos_1 = sword_t'(st_pos[0]);
        o.pos_2 = sword_t'(st_pos[1]);
        o.vel_1 = sword_t'(st_vel[0]);
        o.vel_2 = sword_t'(st_vel[1]);
        o.fault = sat_hit;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Driver, monitor and flow control
    // ---------------------------------------------------------------
    lcrk_in_t  pending_items[$];
    lcrk_out_t expected_states[$];
    bit        in_took = 1'b0;
    bit        calm = 1'b0;
    int        src_gap = 0;
    int        sink_hold = 0;
    int        mismatches = 0;
    int        cycles = 0;

    // predict at the transfer edge
    always @(posedge aclk) begin
        in_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_states.insert(expected_states.size(), rk4_predict(s_data));
        end
    end

    // source side: new item or gap at the falling edge
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_took)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         (calm || $urandom_range(0, 4) != 0)) begin
                s_valid <= 1'b1;
                s_data  <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
                if (!calm && pending_items.size() != 0) src_gap <= $urandom_range(0, 14);
            end
        end
    end

    // sink side: random stall bursts
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 14);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        lcrk_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %p", m_data);
            end else begin
                want = expected_states.pop_front();
                if (m_data.pos_1 !== want.pos_1 || m_data.pos_2 !== want.pos_2 ||
                    m_data.vel_1 !== want.vel_1 || m_data.vel_2 !== want.vel_2 ||
                    m_data.pos_norm_sq !== want.pos_norm_sq ||
                    m_data.fault !== want.fault) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL levi_civita_rk4_step_unit");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic lcrk_in_t mk_item(input bit md, input longint a, input longint b,
                                         input longint c, input longint d);
        lcrk_in_t x;
        x.mode = md;
        x.load_u1 = sword_t'(a);
        x.load_u2 = sword_t'(b);
        x.load_v1 = sword_t'(c);
        x.load_v2 = sword_t'(d);
        return x;
    endfunction

    function automatic longint rnd_near(input int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic longint rnd_full();
        return longint'($signed($urandom()));
    endfunction

    // append one item to the driver queue
    task automatic queue_item(input lcrk_in_t x);
        pending_items.insert(pending_items.size(), x);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_states.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_STEP_SIZE) h_cfg = longint'($signed(val));
        else if (idx == REG_MASS_TERM) mu_cfg = longint'(val & 32'h7FFF_FFFF);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly a load of modest values followed by a few steps; some noise
    task automatic add_random(input int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item(mk_item($urandom_range(0, 1), rnd_full(), rnd_full(),
                                   rnd_full(), rnd_full()));
                n++;
            end else begin
                queue_item(mk_item(1'b0, rnd_near(1 << 18), rnd_near(1 << 18),
                                   rnd_near(1 << 17), rnd_near(1 << 17)));
                n++;
                repeat ($urandom_range(1, 6)) begin
                    queue_item(mk_item(1'b1, rnd_full(), rnd_full(),
                                       rnd_full(), rnd_full()));
                    n++;
                end
            end
        end
    endtask

    initial begin
        st_pos = '{0, 0};
        st_vel = '{0, 0};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset config (h = 0, mu = 1.0)
        queue_item(mk_item(1'b1, 0, 0, 0, 0));               // step from zero state
        queue_item(mk_item(1'b0, SMAX, SMAX, SMAX, SMAX));
        queue_item(mk_item(1'b0, SMIN, SMIN, SMIN, SMIN));
        queue_item(mk_item(1'b1, SMAX, SMIN, 0, -1));
        wait_drained();

        write_reg(REG_STEP_SIZE, 32'h0000_1000);              // h = 1/16
        queue_item(mk_item(1'b0, 0, 0, 65536, 0));            // u = 0, num > 0
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        queue_item(mk_item(1'b0, 0, 0, 0, 0));                // u = 0, num < 0
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        queue_item(mk_item(1'b0, 65536, 0, 0, 65536));        // circular-ish orbit
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        queue_item(mk_item(1'b0, SMAX, SMIN, SMAX, SMIN));
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        queue_item(mk_item(1'b0, -1, 1, -1, 1));
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        wait_drained();

        write_reg(REG_MASS_TERM, 32'h0000_0000);              // mu = 0
        queue_item(mk_item(1'b0, 0, 0, 0, 0));                // u = 0, num = 0
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        queue_item(mk_item(1'b0, 100, -100, 0, 0));
        queue_item(mk_item(1'b1, 0, 0, 0, 0));
        add_random(80);
        wait_drained();

        write_reg(REG_STEP_SIZE, 32'h7FFF_FFFF);
        write_reg(REG_MASS_TERM, 32'hFFFF_FFFF);              // top bit dropped
        add_random(70);
        wait_drained();

        write_reg(REG_STEP_SIZE, 32'h8000_0000);
        write_reg(REG_MASS_TERM, 32'h7FFF_FFFF);
        write_reg(2'd2, $urandom());                          // unused indexes
        write_reg(2'd3, $urandom());
        add_random(70);
        wait_drained();

        write_reg(REG_STEP_SIZE, 32'hFFFF_F800);              // h = -1/32
        write_reg(REG_MASS_TERM, 32'h0001_0000);
        add_random(80);
        wait_drained();

        repeat (2) begin
            write_reg(REG_STEP_SIZE, $urandom_range(0, 1) ? $urandom()
                                                          : $urandom_range(0, 32'h0000_4000));
            write_reg(REG_MASS_TERM, $urandom_range(0, 32'h0004_0000));
            add_random(80);
            wait_drained();
        end

        calm = 1'b1;
        write_reg(REG_STEP_SIZE, 32'h0000_0800);
        add_random(60);
        wait_drained();
        repeat (300) @(posedge aclk);

        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("PASS levi_civita_rk4_step_unit");
        end else begin
            $display("FAIL levi_civita_rk4_step_unit");
        end
        $finish;
    end

endmodule
